[sv/tld_pkg.sv]
// Shared types and constants for the tty line discipline.
// No dependencies; imported by every module of the block.
package tld_pkg;

    localparam int LINE_CAP_DEF = 256;
    localparam int CMDQ_DEPTH   = 2;
    localparam int CFG_IDX_W    = 3;

    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [8:0] LIM_MAX = 9'd256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ERASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_KILL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CHAR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL_CHAR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EOF_CHAR   = 3'd6;

    localparam logic [7:0] ERASE_CHAR_RST = 8'd127;
    localparam logic [7:0] KILL_CHAR_RST  = 8'd21;
    localparam logic [7:0] EOF_CHAR_RST   = 8'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       source_closed;
        logic [8:0] read_limit;
    } t_in;

    typedef struct packed {
        logic        echo_valid;
        logic [7:0]  echo_byte;
        logic [8:0]  erase_echo_count;
        logic [63:0] data_word;
        logic [3:0]  data_count;
        logic        read_done;
        logic [8:0]  read_length;
        logic        last_result;
    } t_res;

    typedef struct packed {
        logic       canonical_on;
        logic       echo_on;
        logic       echo_erase_on;
        logic       echo_kill_on;
        logic [7:0] erase_char;
        logic [7:0] kill_char;
        logic [7:0] eof_char;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NL,
        OP_ERASE,
        OP_KILL,
        OP_END,
        OP_RAW,
        OP_RAW_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [8:0] lim;        // already clamped to 1..256
        logic       echo;       // echo_on
        logic       erase_echo; // echo_on or echo_erase_on
        logic       kill_echo;  // echo_kill_on and echo_on
    } t_cmd;

endpackage

[sv/tld_front.sv]
// Front end: accepts typed bytes and classifies them into line commands.
// Depends on tld_pkg; feeds tld_cmdq.
module tld_front import tld_pkg::*; (
    input  logic i_in_valid,
    input  t_in  i_in_data,
    input  t_cfg i_cfg,
    input  logic i_q_full,
    output logic o_in_stall,
    output logic o_push,
    output t_cmd o_cmd
);

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd            = '0;
        o_cmd.data       = i_in_data.in_byte;
        o_cmd.echo       = i_cfg.echo_on;
        o_cmd.erase_echo = i_cfg.echo_on || i_cfg.echo_erase_on;
        o_cmd.kill_echo  = i_cfg.echo_on && i_cfg.echo_kill_on;

        if (i_in_data.read_limit == 9'd0) begin
            o_cmd.lim = 9'd1;
        end else if (i_in_data.read_limit > LIM_MAX) begin
            o_cmd.lim = LIM_MAX;
        end else begin
            o_cmd.lim = i_in_data.read_limit;
        end

        // priority: raw mode, closed/eof, nl/cr, erase, kill, plain byte
        if (!i_cfg.canonical_on) begin
            o_cmd.op = i_in_data.source_closed ? OP_RAW_END : OP_RAW;
        end else if (i_in_data.source_closed || i_in_data.in_byte == i_cfg.eof_char) begin
            o_cmd.op = OP_END;
        end else if (i_in_data.in_byte == CH_NL || i_in_data.in_byte == CH_CR) begin
            o_cmd.op = OP_NL;
        end else if (i_in_data.in_byte == i_cfg.erase_char) begin
            o_cmd.op = OP_ERASE;
        end else if (i_in_data.in_byte == i_cfg.kill_char) begin
            o_cmd.op = OP_KILL;
        end else begin
            o_cmd.op = OP_CHAR;
        end
    end

endmodule

[sv/tld_cmdq.sv]
// Short command queue between the classifier and the line engine.
// Depends on tld_pkg for the command type and depth.
module tld_cmdq import tld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_entry [CMDQ_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/tld_back.sv]
// Line engine: executes commands on the line store and emits results.
// Depends on tld_pkg; takes commands from tld_cmdq.
module tld_back import tld_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAP_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_out_valid,
    output t_res o_out_data,
    input  logic i_out_stall
);

    localparam int ROWS = (LINE_CAPACITY + 7) / 8;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IW   = $clog2(LINE_CAPACITY);
    localparam int LW   = $clog2(LINE_CAPACITY + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(LINE_CAPACITY);
    localparam logic [IW-1:0] LAST_SLOT = IW'(LINE_CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic        r_ov, n_ov;
    t_res        r_out, n_out;
    logic [RW-1:0] r_row, n_row;
    logic [8:0]  r_left, n_left;
    logic [8:0]  r_dlen, n_dlen;
    logic        r_first, n_first;
    logic        r_echo_v, n_echo_v;
    logic [7:0]  r_echo_b, n_echo_b;
    logic [63:0] r_rdata;
    logic [63:0] r_line_mem [ROWS];

    logic        out_free;
    logic        line_full;
    logic [IW-1:0] slot_pos;
    logic [8:0]  len_ext;
    logic [8:0]  nl_len;
    logic        mem_we;
    logic [7:0]  w_byte;
    logic [RW-1:0] w_row;
    logic [2:0]  w_lane;
    logic [3:0]  emit_cnt;
    logic        emit_last;
    t_res        res;

    assign out_free  = !r_ov || !i_out_stall;
    assign line_full = (r_len == LEN_MAX);
    assign slot_pos  = line_full ? LAST_SLOT : r_len[IW-1:0];
    assign len_ext   = 9'(r_len);
    assign nl_len    = line_full ? len_ext : len_ext + 9'd1;
    assign w_row     = RW'(slot_pos >> 3);
    assign w_lane    = slot_pos[2:0];
    assign w_byte    = (i_cmd.op == OP_NL) ? CH_NL : i_cmd.data;
    assign emit_cnt  = (r_left > 9'd8) ? 4'd8 : r_left[3:0];
    assign emit_last = (r_left <= 9'd8);

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_ov     = r_ov;
        n_out    = r_out;
        n_row    = r_row;
        n_left   = r_left;
        n_dlen   = r_dlen;
        n_first  = r_first;
        n_echo_v = r_echo_v;
        n_echo_b = r_echo_b;
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        res      = '0;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop = 1'b1;
                    res.last_result = 1'b1;
                    n_ov  = 1'b1;
                    case (i_cmd.op)
                        OP_CHAR: begin
                            if (!line_full) begin
                                mem_we = 1'b1;
                                n_len  = r_len + 1'b1;
                                res.echo_valid = i_cmd.echo;
                                res.echo_byte  = i_cmd.echo ? i_cmd.data : 8'd0;
                            end
                        end
                        OP_ERASE: begin
                            if (r_len != '0) begin
                                n_len = r_len - 1'b1;
                                res.erase_echo_count = {8'd0, i_cmd.erase_echo};
                            end
                        end
                        OP_KILL: begin
                            n_len = '0;
                            res.erase_echo_count = i_cmd.erase_echo ? len_ext : 9'd0;
                            res.echo_valid = i_cmd.kill_echo;
                            res.echo_byte  = i_cmd.kill_echo ? CH_NL : 8'd0;
                        end
                        OP_RAW: begin
                            res.echo_valid  = i_cmd.echo;
                            res.echo_byte   = i_cmd.echo ? i_cmd.data : 8'd0;
                            res.data_word   = {56'd0, i_cmd.data};
                            res.data_count  = 4'd1;
                            res.read_done   = 1'b1;
                            res.read_length = 9'd1;
                        end
                        OP_RAW_END: begin
                            res.read_done = 1'b1;
                        end
                        OP_END, OP_NL: begin
                            // the read drains from the store; no result yet
                            n_ov     = r_ov && i_out_stall;
                            n_state  = S_READ;
                            n_row    = '0;
                            n_first  = 1'b1;
                            n_len    = '0;
                            n_echo_v = 1'b0;
                            n_echo_b = 8'd0;
                            if (i_cmd.op == OP_NL) begin
                                mem_we   = 1'b1;
                                n_echo_v = i_cmd.echo;
                                n_echo_b = i_cmd.echo ? CH_NL : 8'd0;
                                n_dlen   = (nl_len < i_cmd.lim) ? nl_len : i_cmd.lim;
                            end else begin
                                n_dlen   = (len_ext < i_cmd.lim) ? len_ext : i_cmd.lim;
                            end
                            n_left = n_dlen;
                        end
                        default: begin
                        end
                    endcase
                    if (n_ov) begin
                        n_out = res;
                    end
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    for (int i = 0; i < 8; i++) begin
                        if (4'(i) < emit_cnt) begin
                            res.data_word[8*i +: 8] = r_rdata[8*i +: 8];
                        end
                    end
                    res.echo_valid       = r_first && r_echo_v;
                    res.echo_byte        = r_first ? r_echo_b : 8'd0;
                    res.data_count       = emit_cnt;
                    res.read_done        = emit_last;
                    res.read_length      = emit_last ? r_dlen : 9'd0;
                    res.last_result      = emit_last;
                    n_out   = res;
                    n_ov    = 1'b1;
                    n_left  = r_left - 9'(emit_cnt);
                    n_row   = r_row + 1'b1;
                    n_first = 1'b0;
                    n_state = emit_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_row    <= n_row;
        r_left   <= n_left;
        r_dlen   <= n_dlen;
        r_first  <= n_first;
        r_echo_v <= n_echo_v;
        r_echo_b <= n_echo_b;
    end

    // line store: byte writes, one 8-byte row read in each S_READ state
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_mem[w_row][{w_lane, 3'b000} +: 8] <= w_byte;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_line_mem[r_row];
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("line length beyond capacity");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.read_done |-> r_out.last_result)
        else $error("read completed on a non-final result");

    a_length_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && (r_out.read_length != 9'd0) |-> r_out.read_done)
        else $error("read length without completed read");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.data_count <= 4'd8) && (r_out.erase_echo_count <= LIM_MAX))
        else $error("result count field out of range");

    a_drain_empties_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_len == '0)
        else $error("line not emptied during read drain");

endmodule

[sv/tty_line_discipline.sv]
// Top level of the tty line discipline: config registers, classifier,
// command queue and line engine. Depends on tld_pkg, tld_front, tld_cmdq, tld_back.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------
//  in      | in  | i_in_valid/o_in_stall | t_in: byte, closed, limit
//  out     | out | o_out_valid/i_out_stall | t_res: echo, data, read info
//  cfg     | in  | i_cfg_valid/o_cfg_ready | 3-bit index, 8-bit data
//
// A byte enters the two-deep command queue in the cycle it is offered,
// unless the queue is full. Editing commands give one result each. A
// finished read of L bytes gives max(1, ceil(L/8)) results: the engine
// takes the command, then for each result reads one row from the line
// store (S_READ) and then loads the output register (S_EMIT).
// Reset empties the line and restores the register defaults; the store
// itself is not cleared. Output stall holds the engine; a full queue
// stalls the input.
module tty_line_discipline import tld_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAP_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_res                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg r_cfg;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd cmd_in;
    t_cmd cmd_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.canonical_on  <= 1'b1;
            r_cfg.echo_on       <= 1'b1;
            r_cfg.echo_erase_on <= 1'b1;
            r_cfg.echo_kill_on  <= 1'b1;
            r_cfg.erase_char    <= ERASE_CHAR_RST;
            r_cfg.kill_char     <= KILL_CHAR_RST;
            r_cfg.eof_char      <= EOF_CHAR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CANONICAL:  r_cfg.canonical_on  <= i_cfg_data[0];
                CFG_ECHO:       r_cfg.echo_on       <= i_cfg_data[0];
                CFG_ECHO_ERASE: r_cfg.echo_erase_on <= i_cfg_data[0];
                CFG_ECHO_KILL:  r_cfg.echo_kill_on  <= i_cfg_data[0];
                CFG_ERASE_CHAR: r_cfg.erase_char    <= i_cfg_data;
                CFG_KILL_CHAR:  r_cfg.kill_char     <= i_cfg_data;
                CFG_EOF_CHAR:   r_cfg.eof_char      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tld_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    tld_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (cmd_out),
        .o_empty (q_empty)
    );

    tld_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
